/* rtl/sac_pkg.sv */
// Shared widths, constants and types of the swept box collision block.
package sac_pkg;

    // Field widths of the item and result beats.
    localparam int COORD_W = 24;
    localparam int SIZE_W  = 23;
    localparam int PT_W    = 26;
    localparam int NRM_W   = 2;
    localparam int HT_W    = 16;
    localparam int ENT_W   = 32;

    // Fraction bits of every time value.
    localparam int TIME_FRAC_BITS = 16;

    // Slab numerators need two more bits than a coordinate.
    localparam int NUM_W = COORD_W + 2;

    // Divider geometry: two quotient bits per pipeline stage.
    localparam int DVD_W     = NUM_W + TIME_FRAC_BITS;
    localparam int DIV_STEPS = (DVD_W + 1) / 2;
    localparam int QW        = 2 * DIV_STEPS;
    localparam int REM_W     = COORD_W;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    // Internal time width, with room for the infinite markers.
    localparam int TIME_W = QW + 2;
    localparam logic signed [TIME_W-1:0] TIME_INF  = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic signed [TIME_W-1:0] TIME_NINF = -TIME_INF;
    localparam logic signed [TIME_W-1:0] TIME_ONE  =
        TIME_W'(1) <<< TIME_FRAC_BITS;
    localparam logic signed [TIME_W-1:0] ENT_MAX =
        TIME_W'({1'b0, {(ENT_W-1){1'b1}}});
    localparam logic signed [TIME_W-1:0] ENT_MIN = -ENT_MAX - TIME_W'(1);

    // Contact point arithmetic.
    localparam int PROD_W = COORD_W + TIME_FRAC_BITS + 1;
    localparam int OFF_W  = PROD_W - TIME_FRAC_BITS + 1;
    localparam int SUM_W  = PT_W + 1;
    localparam logic signed [SUM_W-1:0] PT_MAX = SUM_W'({1'b0, {(PT_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] PT_MIN = -PT_MAX - SUM_W'(1);

    // Normal component codes.
    localparam logic signed [NRM_W-1:0] NRM_POS  = 2'sb01;
    localparam logic signed [NRM_W-1:0] NRM_NEG  = 2'sb11;
    localparam logic signed [NRM_W-1:0] NRM_ZERO = 2'sb00;

    // Values that ride along beside the dividers.
    typedef struct packed {
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic signed [PT_W-1:0]    base_x;
        logic signed [PT_W-1:0]    base_y;
        logic                      ins_x;
        logic                      ins_y;
    } t_side;

endpackage

/* rtl/sac_if.sv */
// Handshake channels for box pair beats and collision result beats.
interface sac_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sac_pkg::COORD_W-1:0]  a_min_x;
    logic signed [sac_pkg::COORD_W-1:0]  a_min_y;
    logic        [sac_pkg::SIZE_W-1:0]   a_size_x;
    logic        [sac_pkg::SIZE_W-1:0]   a_size_y;
    logic signed [sac_pkg::COORD_W-1:0]  b_min_x;
    logic signed [sac_pkg::COORD_W-1:0]  b_min_y;
    logic        [sac_pkg::SIZE_W-1:0]   b_size_x;
    logic        [sac_pkg::SIZE_W-1:0]   b_size_y;
    logic signed [sac_pkg::COORD_W-1:0]  disp_x;
    logic signed [sac_pkg::COORD_W-1:0]  disp_y;

    modport source (
        output valid, a_min_x, a_min_y, a_size_x, a_size_y,
               b_min_x, b_min_y, b_size_x, b_size_y, disp_x, disp_y,
        input  ready
    );
    modport sink (
        input  valid, a_min_x, a_min_y, a_size_x, a_size_y,
               b_min_x, b_min_y, b_size_x, b_size_y, disp_x, disp_y,
        output ready
    );
endinterface

interface sac_out_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic signed [sac_pkg::PT_W-1:0]    point_x;
    logic signed [sac_pkg::PT_W-1:0]    point_y;
    logic signed [sac_pkg::NRM_W-1:0]   normal_x;
    logic signed [sac_pkg::NRM_W-1:0]   normal_y;
    logic        [sac_pkg::HT_W-1:0]    hit_time;
    logic signed [sac_pkg::ENT_W-1:0]   entry_x;
    logic signed [sac_pkg::ENT_W-1:0]   entry_y;

    modport source (
        output valid, hit, point_x, point_y, normal_x, normal_y,
               hit_time, entry_x, entry_y,
        input  ready
    );
    modport sink (
        input  valid, hit, point_x, point_y, normal_x, normal_y,
               hit_time, entry_x, entry_y,
        output ready
    );
endinterface

/* rtl/sac_div.sv */
// Pipelined signed floor divider producing a slab time, two quotient bits per stage.
module sac_div
    import sac_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [NUM_W-1:0]  i_num,
    input  logic signed [COORD_W-1:0] i_den,
    output logic signed [TIME_W-1:0] o_quot
);

    logic [QW-1:0]    r_dq  [0:DIV_STEPS];
    logic [REM_W-1:0] r_rem [0:DIV_STEPS];
    logic [REM_W-1:0] r_dvs [0:DIV_STEPS];
    logic             r_neg [0:DIV_STEPS];
    logic signed [TIME_W-1:0] r_quot;

    logic [NUM_W-1:0]   num_mag;
    logic [COORD_W-1:0] den_mag;

    // Load stage: magnitudes, dividend scaled by the time fraction.
    always_comb begin
        num_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        den_mag = i_den[COORD_W-1] ? COORD_W'(-i_den) : COORD_W'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dq[0]  <= QW'({num_mag, {TIME_FRAC_BITS{1'b0}}});
            r_rem[0] <= '0;
            r_dvs[0] <= den_mag;
            r_neg[0] <= i_num[NUM_W-1] ^ i_den[COORD_W-1];
        end
    end

    // Restoring division steps: the dividend shifts out the top while
    // quotient bits shift in at the bottom.
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic [QW-1:0]    n_dq;
        logic [REM_W-1:0] n_rem;

        always_comb begin
            logic [REM_W:0] trial;
            n_dq  = r_dq[s];
            n_rem = r_rem[s];
            for (int k = 0; k < 2; k++) begin
                trial = {n_rem, n_dq[QW-1]};
                n_dq  = n_dq << 1;
                if (trial >= {1'b0, r_dvs[s]}) begin
                    trial   = trial - {1'b0, r_dvs[s]};
                    n_dq[0] = 1'b1;
                end
                n_rem = trial[REM_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[s+1]  <= n_dq;
                r_rem[s+1] <= n_rem;
                r_dvs[s+1] <= r_dvs[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    // Sign fixup: a negative quotient with a remainder rounds down.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[DIV_STEPS]) begin
                r_quot <= -(TIME_W'(r_dq[DIV_STEPS])
                            + TIME_W'(r_rem[DIV_STEPS] != '0));
            end else begin
                r_quot <= TIME_W'(r_dq[DIV_STEPS]);
            end
        end
    end

    assign o_quot = r_quot;

endmodule

/* rtl/swept_aabb_collision.sv */
// Top level of the swept box collision block: slab test pipeline around four dividers.
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------
//  i_in    | in  | box A and B corners and sizes, displacement
//  o_out   | out | hit, contact point, normal, hit time, entry times
//
// One beat enters per cycle while o_out does not stall; its result passes stage A, the
// slab dividers and stages C to F, and waits in the result register until taken.
// The slab dividers retire two quotient bits a stage.
// Reset clears only the valid bits of the stages.
// A stall on o_out freezes the whole pipeline; i_in.ready follows it.
module swept_aabb_collision
    import sac_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sac_in_if.sink     i_in,
    sac_out_if.source  o_out
);

    logic en;
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // Stage A: slab numerators, contact base, inside flags.
    logic                      r_va;
    logic signed [NUM_W-1:0]   r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    t_side                     r_sa;
    logic signed [NUM_W-1:0]   n_lo_x, n_hi_x, n_lo_y, n_hi_y;
    logic signed [NUM_W-1:0]   ax, ay, asx, asy, bx, by, bsx, bsy;

    always_comb begin
        ax  = NUM_W'(i_in.a_min_x);
        ay  = NUM_W'(i_in.a_min_y);
        bx  = NUM_W'(i_in.b_min_x);
        by  = NUM_W'(i_in.b_min_y);
        asx = $signed(NUM_W'(i_in.a_size_x));
        asy = $signed(NUM_W'(i_in.a_size_y));
        bsx = $signed(NUM_W'(i_in.b_size_x));
        bsy = $signed(NUM_W'(i_in.b_size_y));
        n_lo_x = bx - ax - asx;
        n_hi_x = bx + bsx - ax;
        n_lo_y = by - ay - asy;
        n_hi_y = by + bsy - ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en) begin
            r_va <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lo_x      <= n_lo_x;
            r_hi_x      <= n_hi_x;
            r_lo_y      <= n_lo_y;
            r_hi_y      <= n_hi_y;
            r_sa.dx     <= i_in.disp_x;
            r_sa.dy     <= i_in.disp_y;
            r_sa.base_x <= (ax <<< 1) + asx;
            r_sa.base_y <= (ay <<< 1) + asy;
            r_sa.ins_x  <= (n_lo_x <= 0) && (n_hi_x >= 0);
            r_sa.ins_y  <= (n_lo_y <= 0) && (n_hi_y >= 0);
        end
    end

    // Slab dividers, one per near and far numerator.
    logic signed [TIME_W-1:0] q_lo_x, q_hi_x, q_lo_y, q_hi_y;

    sac_div u_div_lo_x (.i_clk, .i_en(en), .i_num(r_lo_x), .i_den(r_sa.dx), .o_quot(q_lo_x));
    sac_div u_div_hi_x (.i_clk, .i_en(en), .i_num(r_hi_x), .i_den(r_sa.dx), .o_quot(q_hi_x));
    sac_div u_div_lo_y (.i_clk, .i_en(en), .i_num(r_lo_y), .i_den(r_sa.dy), .o_quot(q_lo_y));
    sac_div u_div_hi_y (.i_clk, .i_en(en), .i_num(r_hi_y), .i_den(r_sa.dy), .o_quot(q_hi_y));

    // Side values and valid bits delayed to match the dividers.
    logic  r_sv [0:DIV_LAT-1];
    t_side r_sd [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_sv[i] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= r_va;
            for (int i = 1; i < DIV_LAT; i++) r_sv[i] <= r_sv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r_sa;
            for (int i = 1; i < DIV_LAT; i++) r_sd[i] <= r_sd[i-1];
        end
    end

    // Stage C: zero direction handling and near/far ordering.
    t_side                    sc;
    logic                     r_vc, r_mc;
    t_side                    r_sc;
    logic signed [TIME_W-1:0] r_nx, r_fx, r_ny, r_fy;
    logic signed [TIME_W-1:0] n_nx, n_fx, n_ny, n_fy;
    logic                     n_mc;

    assign sc = r_sd[DIV_LAT-1];

    always_comb begin
        n_mc = 1'b0;
        if (sc.dx == '0) begin
            n_nx = TIME_NINF;
            n_fx = TIME_INF;
            if (!sc.ins_x) n_mc = 1'b1;
        end else if (q_lo_x > q_hi_x) begin
            n_nx = q_hi_x;
            n_fx = q_lo_x;
        end else begin
            n_nx = q_lo_x;
            n_fx = q_hi_x;
        end
        if (sc.dy == '0) begin
            n_ny = TIME_NINF;
            n_fy = TIME_INF;
            if (!sc.ins_y) n_mc = 1'b1;
        end else if (q_lo_y > q_hi_y) begin
            n_ny = q_hi_y;
            n_fy = q_lo_y;
        end else begin
            n_ny = q_lo_y;
            n_fy = q_hi_y;
        end
        if (sc.dx == '0 && sc.dy == '0) n_mc = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (en) begin
            r_vc <= r_sv[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mc <= n_mc;
            r_sc <= sc;
            r_nx <= n_nx;
            r_fx <= n_fx;
            r_ny <= n_ny;
            r_fy <= n_fy;
        end
    end

    // Stage D: overlap, entry time range, normal and saturated entries.
    logic                        r_vd, r_hd;
    t_side                       r_sdd;
    logic [TIME_FRAC_BITS-1:0]   r_td;
    logic signed [NRM_W-1:0]     r_nrm_x, r_nrm_y;
    logic signed [ENT_W-1:0]     r_ent_x, r_ent_y;
    logic signed [TIME_W-1:0]    tmin_d;
    logic                        hit_d;

    function automatic logic signed [ENT_W-1:0] sat_ent(input logic signed [TIME_W-1:0] v);
        logic signed [ENT_W-1:0] r;
        if (v > ENT_MAX) r = ENT_MAX[ENT_W-1:0];
        else if (v < ENT_MIN) r = ENT_MIN[ENT_W-1:0];
        else r = v[ENT_W-1:0];
        return r;
    endfunction

    always_comb begin
        tmin_d = (r_nx > r_ny) ? r_nx : r_ny;
        hit_d  = !r_mc && !(r_nx > r_fy) && !(r_ny > r_fx)
                 && (tmin_d >= 0) && (tmin_d < TIME_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (en) begin
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hd    <= hit_d;
            r_sdd   <= r_sc;
            r_td    <= tmin_d[TIME_FRAC_BITS-1:0];
            r_ent_x <= sat_ent(r_nx);
            r_ent_y <= sat_ent(r_ny);
            if (r_nx > r_ny) begin
                r_nrm_x <= (r_sc.dx < 0) ? NRM_POS : NRM_NEG;
                r_nrm_y <= NRM_ZERO;
            end else begin
                r_nrm_x <= NRM_ZERO;
                r_nrm_y <= (r_sc.dy < 0) ? NRM_POS : NRM_NEG;
            end
        end
    end

    // Stage E: displacement times entry time.
    logic                      r_ve, r_he;
    logic [TIME_FRAC_BITS-1:0] r_te;
    logic signed [NRM_W-1:0]   r_nrm_xe, r_nrm_ye;
    logic signed [ENT_W-1:0]   r_ent_xe, r_ent_ye;
    logic signed [PT_W-1:0]    r_base_x, r_base_y;
    logic signed [PROD_W-1:0]  r_prod_x, r_prod_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (en) begin
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_he     <= r_hd;
            r_te     <= r_td;
            r_nrm_xe <= r_nrm_x;
            r_nrm_ye <= r_nrm_y;
            r_ent_xe <= r_ent_x;
            r_ent_ye <= r_ent_y;
            r_base_x <= r_sdd.base_x;
            r_base_y <= r_sdd.base_y;
            r_prod_x <= PROD_W'(r_sdd.dx) * $signed({1'b0, r_td});
            r_prod_y <= PROD_W'(r_sdd.dy) * $signed({1'b0, r_td});
        end
    end

    // Stage F: contact point with saturation, result register.
    logic                     r_vo;
    logic signed [OFF_W-1:0]  off_x, off_y;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic signed [PT_W-1:0]   pt_x, pt_y;

    always_comb begin
        off_x = OFF_W'(r_prod_x >>> (TIME_FRAC_BITS - 1));
        off_y = OFF_W'(r_prod_y >>> (TIME_FRAC_BITS - 1));
        sum_x = SUM_W'(r_base_x) + SUM_W'(off_x);
        sum_y = SUM_W'(r_base_y) + SUM_W'(off_y);
        if (sum_x > PT_MAX) pt_x = PT_MAX[PT_W-1:0];
        else if (sum_x < PT_MIN) pt_x = PT_MIN[PT_W-1:0];
        else pt_x = sum_x[PT_W-1:0];
        if (sum_y > PT_MAX) pt_y = PT_MAX[PT_W-1:0];
        else if (sum_y < PT_MIN) pt_y = PT_MIN[PT_W-1:0];
        else pt_y = sum_y[PT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_ve;
        end
    end

    // A miss clears every field of the beat.
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out.hit      <= r_he;
            o_out.point_x  <= r_he ? pt_x : '0;
            o_out.point_y  <= r_he ? pt_y : '0;
            o_out.normal_x <= r_he ? r_nrm_xe : NRM_ZERO;
            o_out.normal_y <= r_he ? r_nrm_ye : NRM_ZERO;
            o_out.hit_time <= r_he ? HT_W'(r_te) : '0;
            o_out.entry_x  <= r_he ? r_ent_xe : '0;
            o_out.entry_y  <= r_he ? r_ent_ye : '0;
        end
    end

    assign o_out.valid = r_vo;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the swept box collision block.
module testbench
    import sac_pkg::*;
;

    localparam int LATENCY = DIV_LAT + 5;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_min_x;
        logic signed [COORD_W-1:0] a_min_y;
        logic [SIZE_W-1:0]         a_size_x;
        logic [SIZE_W-1:0]         a_size_y;
        logic signed [COORD_W-1:0] b_min_x;
        logic signed [COORD_W-1:0] b_min_y;
        logic [SIZE_W-1:0]         b_size_x;
        logic [SIZE_W-1:0]         b_size_y;
        logic signed [COORD_W-1:0] disp_x;
        logic signed [COORD_W-1:0] disp_y;
    } t_box_pair;

    typedef struct packed {
        logic                      hit;
        logic signed [PT_W-1:0]    point_x;
        logic signed [PT_W-1:0]    point_y;
        logic signed [NRM_W-1:0]   normal_x;
        logic signed [NRM_W-1:0]   normal_y;
        logic [HT_W-1:0]           hit_time;
        logic signed [ENT_W-1:0]   entry_x;
        logic signed [ENT_W-1:0]   entry_y;
    } t_contact;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    sac_in_if  pair_ch ();
    sac_out_if hit_ch ();

    t_contact pending_contacts[$];
    int errors = 0;
    int pairs_sent = 0;
    int contacts_seen = 0;
    int hits_seen = 0;
    int idle_cycles = 0;
    bit allow_gaps = 1'b1;

    swept_aabb_collision uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pair_ch),
        .o_out  (hit_ch)
    );

    always #4 i_clk = ~i_clk;

    // Floor division on wide signed values.
    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
        return q;
    endfunction

    // Slab interval of one axis; returns 0 when that axis alone misses.
    function automatic bit axis_interval(longint lo_num, longint hi_num, longint d,
                                         output longint t_near, output longint t_far);
        longint n;
        longint f;
        longint s;
        if (d == 0) begin
            t_near = -(64'sd1 <<< 60);
            t_far = 64'sd1 <<< 60;
            return lo_num <= 0 && hi_num >= 0;
        end
        n = div_floor(lo_num <<< TIME_FRAC_BITS, d);
        f = div_floor(hi_num <<< TIME_FRAC_BITS, d);
        if (n > f) begin
            s = n;
            n = f;
            f = s;
        end
        t_near = n;
        t_far = f;
        return 1'b1;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint contact_coord(longint amin, longint asize, longint d,
                                             longint t);
        longint p;
        p = 2 * amin + asize + div_floor(2 * d * t, 64'sd1 <<< TIME_FRAC_BITS);
        return clamp(p, -(64'sd1 <<< 25), (64'sd1 <<< 25) - 1);
    endfunction

    // Works out the collision result of one box pair.
    function automatic t_contact sweep_contact(t_box_pair p);
        t_contact r;
        longint ax, ay, asx, asy, bx, by, bsx, bsy, dx, dy;
        longint nx, fx, ny, fy, t;
        r = '0;
        ax = p.a_min_x; ay = p.a_min_y;
        asx = longint'(p.a_size_x); asy = longint'(p.a_size_y);
        bx = p.b_min_x; by = p.b_min_y;
        bsx = longint'(p.b_size_x); bsy = longint'(p.b_size_y);
        dx = p.disp_x; dy = p.disp_y;
        if (dx == 0 && dy == 0) return r;
        if (!axis_interval(bx - ax - asx, bx + bsx - ax, dx, nx, fx)) return r;
        if (!axis_interval(by - ay - asy, by + bsy - ay, dy, ny, fy)) return r;
        if (nx > fy || ny > fx) return r;
        t = nx > ny ? nx : ny;
        if (t < 0 || t >= (64'sd1 <<< TIME_FRAC_BITS)) return r;
        r.hit = 1'b1;
        if (nx > ny) begin
            r.normal_x = dx < 0 ? NRM_POS : NRM_NEG;
            r.normal_y = NRM_ZERO;
        end else begin
            r.normal_y = dy < 0 ? NRM_POS : NRM_NEG;
            r.normal_x = NRM_ZERO;
        end
        r.point_x = PT_W'(contact_coord(ax, asx, dx, t));
        r.point_y = PT_W'(contact_coord(ay, asy, dy, t));
        r.hit_time = HT_W'(t);
        r.entry_x = ENT_W'(clamp(nx, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
        r.entry_y = ENT_W'(clamp(ny, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
        return r;
    endfunction

    // Sends one box pair beat, at times with a random gap ahead of it while gaps are allowed.
    task automatic send_pair(t_box_pair p);
        int gap;
        gap = 0;
        if (allow_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pair_ch.valid    <= 1'b1;
        pair_ch.a_min_x  <= p.a_min_x;
        pair_ch.a_min_y  <= p.a_min_y;
        pair_ch.a_size_x <= p.a_size_x;
        pair_ch.a_size_y <= p.a_size_y;
        pair_ch.b_min_x  <= p.b_min_x;
        pair_ch.b_min_y  <= p.b_min_y;
        pair_ch.b_size_x <= p.b_size_x;
        pair_ch.b_size_y <= p.b_size_y;
        pair_ch.disp_x   <= p.disp_x;
        pair_ch.disp_y   <= p.disp_y;
        @(posedge i_clk);
        while (!pair_ch.ready) @(posedge i_clk);
        pending_contacts = {pending_contacts, sweep_contact(p)};
        pairs_sent++;
    endtask

    // Fully random fields, every bit free.
    function automatic t_box_pair random_pair();
        t_box_pair p;
        p.a_min_x = COORD_W'($urandom); p.a_min_y = COORD_W'($urandom);
        p.a_size_x = SIZE_W'($urandom); p.a_size_y = SIZE_W'($urandom);
        p.b_min_x = COORD_W'($urandom); p.b_min_y = COORD_W'($urandom);
        p.b_size_x = SIZE_W'($urandom); p.b_size_y = SIZE_W'($urandom);
        p.disp_x = COORD_W'($urandom); p.disp_y = COORD_W'($urandom);
        return p;
    endfunction

    // Boxes near each other, moving toward one another, so most pairs hit.
    function automatic t_box_pair near_pair();
        t_box_pair p;
        int span;
        span = 1 << $urandom_range(4, 22);
        p.a_min_x = COORD_W'($signed($urandom_range(0, 2 * span)) - span);
        p.a_min_y = COORD_W'($signed($urandom_range(0, 2 * span)) - span);
        p.a_size_x = SIZE_W'($urandom_range(0, span));
        p.a_size_y = SIZE_W'($urandom_range(0, span));
        p.b_min_x = COORD_W'($signed($urandom_range(0, 2 * span)) - span);
        p.b_min_y = COORD_W'($signed($urandom_range(0, 2 * span)) - span);
        p.b_size_x = SIZE_W'($urandom_range(0, span));
        p.b_size_y = SIZE_W'($urandom_range(0, span));
        p.disp_x = COORD_W'(($urandom_range(0, 5) == 0) ? 0 :
                   (p.b_min_x - p.a_min_x) + $signed($urandom_range(0, span)) - span / 2);
        p.disp_y = COORD_W'(($urandom_range(0, 5) == 0) ? 0 :
                   (p.b_min_y - p.a_min_y) + $signed($urandom_range(0, span)) - span / 2);
        return p;
    endfunction

    // Builds a pair from small integer parts in whole units.
    function automatic t_box_pair unit_pair(int ax, int ay, int asx, int asy, int bx, int by,
                                            int bsx, int bsy, int dx, int dy);
        t_box_pair p;
        p.a_min_x = COORD_W'(ax * 256); p.a_min_y = COORD_W'(ay * 256);
        p.a_size_x = SIZE_W'(asx * 256); p.a_size_y = SIZE_W'(asy * 256);
        p.b_min_x = COORD_W'(bx * 256); p.b_min_y = COORD_W'(by * 256);
        p.b_size_x = SIZE_W'(bsx * 256); p.b_size_y = SIZE_W'(bsy * 256);
        p.disp_x = COORD_W'(dx * 256); p.disp_y = COORD_W'(dy * 256);
        return p;
    endfunction

    // Result checker with random stalls on the result side.
    always @(posedge i_clk) begin
        t_contact got;
        t_contact want;
        if (!i_rst_n) begin
            hit_ch.ready <= 1'b0;
        end else begin
            if (hit_ch.valid && hit_ch.ready) begin
                got = '{hit_ch.hit, hit_ch.point_x, hit_ch.point_y, hit_ch.normal_x,
                        hit_ch.normal_y, hit_ch.hit_time, hit_ch.entry_x, hit_ch.entry_y};
                contacts_seen++;
                if (got.hit) hits_seen++;
                if (pending_contacts.size() == 0) begin
                    $error("unexpected result beat");
                    errors++;
                end else begin
                    want = pending_contacts.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d got %0d", want.hit, got.hit); errors++;
                    end
                    if (got.point_x !== want.point_x) begin
                        $error("point_x: expected %0d got %0d", want.point_x, got.point_x);
                        errors++;
                    end
                    if (got.point_y !== want.point_y) begin
                        $error("point_y: expected %0d got %0d", want.point_y, got.point_y);
                        errors++;
                    end
                    if (got.normal_x !== want.normal_x) begin
                        $error("normal_x: expected %0d got %0d", want.normal_x, got.normal_x);
                        errors++;
                    end
                    if (got.normal_y !== want.normal_y) begin
                        $error("normal_y: expected %0d got %0d", want.normal_y, got.normal_y);
                        errors++;
                    end
                    if (got.hit_time !== want.hit_time) begin
                        $error("hit_time: expected %0d got %0d", want.hit_time, got.hit_time);
                        errors++;
                    end
                    if (got.entry_x !== want.entry_x) begin
                        $error("entry_x: expected %0d got %0d", want.entry_x, got.entry_x);
                        errors++;
                    end
                    if (got.entry_y !== want.entry_y) begin
                        $error("entry_y: expected %0d got %0d", want.entry_y, got.entry_y);
                        errors++;
                    end
                end
            end
            // Random stall bursts, only while gaps are allowed.
            if (!allow_gaps) hit_ch.ready <= 1'b1;
            else if (!hit_ch.ready) hit_ch.ready <= ($urandom_range(0, 2) != 0);
            else hit_ch.ready <= ($urandom_range(0, 5) != 0);
        end
    end

    // Watchdog on cycles with no beat accepted on either side.
    always @(posedge i_clk) begin
        if ((pair_ch.valid && pair_ch.ready) || (hit_ch.valid && hit_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_extremes();
        t_box_pair p;
        p = '0;
        send_pair(p);                        // zero displacement misses
        p.a_min_x = 24'sh800000; p.a_min_y = 24'sh7FFFFF;
        p.a_size_x = '1; p.a_size_y = '1;
        p.b_min_x = 24'sh7FFFFF; p.b_min_y = 24'sh800000;
        p.b_size_x = '1; p.b_size_y = '1;
        p.disp_x = 24'sh7FFFFF; p.disp_y = 24'sh800000;
        send_pair(p);
        p.disp_x = 24'sh800000; p.disp_y = 24'sh7FFFFF;
        send_pair(p);
        p.disp_x = 24'sh000001; p.disp_y = 24'shFFFFFF;
        send_pair(p);
        p = '1;
        send_pair(p);
    endtask

    task automatic test_axis_cases();
        send_pair(unit_pair(0, 0, 2, 2, 5, 0, 2, 2, 10, 0));   // X face, dy zero inside
        send_pair(unit_pair(0, 0, 2, 2, 5, 9, 2, 2, 10, 0));   // dy zero outside slab
        send_pair(unit_pair(0, 0, 2, 2, 0, 5, 2, 2, 0, 10));   // Y face from below
        send_pair(unit_pair(0, 9, 2, 2, 0, 0, 2, 2, 0, -10));  // Y face from above
        send_pair(unit_pair(9, 0, 2, 2, 0, 0, 2, 2, -10, 0));  // X face from the right
        send_pair(unit_pair(0, 0, 2, 2, 4, 4, 2, 2, 4, 4));    // tie goes to Y
        send_pair(unit_pair(0, 0, 2, 2, 2, 0, 2, 2, 4, 0));    // touching, t zero
        send_pair(unit_pair(0, 0, 2, 2, 5, 0, 2, 2, 3, 0));    // t exactly one
        send_pair(unit_pair(0, 0, 2, 2, 5, 0, 2, 2, -3, 0));   // moving away
        send_pair(unit_pair(1, 1, 2, 2, 0, 0, 4, 4, 3, 1));    // start overlapped
        send_pair(unit_pair(0, 0, 2, 2, 5, 20, 2, 2, 10, 10)); // slabs do not overlap
        send_pair(unit_pair(0, 0, 0, 0, 5, 5, 0, 0, 10, 10));  // zero sizes
    endtask

    task automatic test_random_mix(int count);
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) send_pair(random_pair());
            else send_pair(near_pair());
        end
    endtask

    initial begin
        pair_ch.valid <= 1'b0;
        pair_ch.a_min_x <= '0; pair_ch.a_min_y <= '0;
        pair_ch.a_size_x <= '0; pair_ch.a_size_y <= '0;
        pair_ch.b_min_x <= '0; pair_ch.b_min_y <= '0;
        pair_ch.b_size_x <= '0; pair_ch.b_size_y <= '0;
        pair_ch.disp_x <= '0; pair_ch.disp_y <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_axis_cases();
        test_random_mix(600);
        allow_gaps = 1'b0;
        test_random_mix(150);
        pair_ch.valid <= 1'b0;
        while (pending_contacts.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Sent %0d box pairs, checked %0d results, %0d of them hits.",
                 pairs_sent, contacts_seen, hits_seen);
        if (errors == 0 && pending_contacts.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/sac_pkg.sv
rtl/sac_if.sv
rtl/sac_div.sv
rtl/swept_aabb_collision.sv
test/testbench.sv
